FILE: sv/assert_macros.svh
// Assertion macros used by the ranger top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define UER_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition is followed by another in the next cycle.
`define UER_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/uer_pkg.sv
// Shared types and constants of the ultrasonic echo ranger.
`default_nettype none

package uer_pkg;

   localparam int TRIG_W   = 20;
   localparam int TIME_W   = 24;
   localparam int COEFF_W  = 20;
   localparam int COUNT_W  = 24;
   localparam int DIST_W   = 28;
   localparam int PROD_W   = COUNT_W + COEFF_W;
   localparam int FRAC_W   = 16;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam logic [TRIG_W-1:0]  TRIG_RESET    = 20'd20000;
   localparam logic [TIME_W-1:0]  TIMEOUT_RESET = 24'd2000000;
   localparam logic [COEFF_W-1:0] COEFF_RESET   = 20'd112394;

   // Register indexes, taken from paddr[3:2].
   localparam logic [1:0] REG_TRIGGER = 2'd0;
   localparam logic [1:0] REG_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_COEFF   = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_TRIG      = 3'd1,
      PH_WAIT_LOW  = 3'd2,
      PH_WAIT_HIGH = 3'd3,
      PH_COUNT     = 3'd4
   } phase_type;

   typedef struct packed {
      logic               trigger_level;
      logic               done_res;
      logic               timed_out;
      logic               valid_res;
      logic [COUNT_W-1:0] echo_count;
   } ctrl_result_type;

endpackage

`default_nettype wire

FILE: sv/uer_ctrl.sv
// Measurement sequencer: trigger pulse, echo waits, echo counting and timeout.
`default_nettype none

module uer_ctrl (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                step,
   input  wire                                start_req,
   input  wire                                echo_level,
   input  wire  [uer_pkg::TRIG_W-1:0]         trigger_ticks,
   input  wire  [uer_pkg::TIME_W-1:0]         timeout_ticks,
   output uer_pkg::ctrl_result_type           result
);

   uer_pkg::phase_type              phase_ff, phase_in;
   logic [uer_pkg::TRIG_W-1:0]      pulse_ff, pulse_in;
   logic [uer_pkg::TIME_W-1:0]      elapsed_ff, elapsed_in;
   logic [uer_pkg::COUNT_W-1:0]     high_ff, high_in;
   logic                            tmo_ff, tmo_in;
   logic                            hit_ff, hit_in;

   logic [uer_pkg::TRIG_W-1:0]      trig_len;
   logic [uer_pkg::TIME_W-1:0]      limit;
   logic                            done;
   logic                            ended;

   assign trig_len = (trigger_ticks == '0) ? uer_pkg::TRIG_W'(1) : trigger_ticks;
   assign limit    = (timeout_ticks == '0) ? uer_pkg::TIME_W'(1) : timeout_ticks;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= uer_pkg::PH_IDLE;
         pulse_ff   <= '0;
         elapsed_ff <= '0;
         high_ff    <= '0;
         tmo_ff     <= 1'b0;
         hit_ff     <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         pulse_ff   <= pulse_in;
         elapsed_ff <= elapsed_in;
         high_ff    <= high_in;
         tmo_ff     <= tmo_in;
         hit_ff     <= hit_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      pulse_in   = pulse_ff;
      elapsed_in = elapsed_ff;
      high_in    = high_ff;
      tmo_in     = tmo_ff;
      hit_in     = hit_ff;
      done       = 1'b0;
      ended      = 1'b0;
      case (phase_ff)
         uer_pkg::PH_TRIG: begin
            if (pulse_ff >= trig_len) begin
               phase_in   = uer_pkg::PH_WAIT_LOW;
               elapsed_in = '0;
            end else begin
               pulse_in = pulse_ff + 1'b1;
            end
         end
         uer_pkg::PH_WAIT_LOW, uer_pkg::PH_WAIT_HIGH, uer_pkg::PH_COUNT: begin
            if (elapsed_ff != '1) begin
               elapsed_in = elapsed_ff + 1'b1;
            end
            if (phase_ff == uer_pkg::PH_WAIT_LOW) begin
               if (!echo_level) begin
                  phase_in = uer_pkg::PH_WAIT_HIGH;
               end
            end else if (phase_ff == uer_pkg::PH_WAIT_HIGH) begin
               if (echo_level) begin
                  phase_in = uer_pkg::PH_COUNT;
                  high_in  = uer_pkg::COUNT_W'(1);
               end
            end else if (echo_level) begin
               if (high_ff != '1) begin
                  high_in = high_ff + 1'b1;
               end
            end else begin
               ended = 1'b1;
            end
            // The echo end wins over a timeout that falls on the same tick.
            if (ended || (elapsed_in >= limit)) begin
               phase_in = uer_pkg::PH_IDLE;
               done     = 1'b1;
               tmo_in   = !ended;
               hit_in   = (high_in != '0);
            end
         end
         default: begin
            phase_in = uer_pkg::PH_IDLE;
            if (start_req) begin
               phase_in   = uer_pkg::PH_TRIG;
               pulse_in   = uer_pkg::TRIG_W'(1);
               elapsed_in = '0;
               high_in    = '0;
               tmo_in     = 1'b0;
               hit_in     = 1'b0;
            end
         end
      endcase
   end

   assign result.trigger_level = (phase_in == uer_pkg::PH_TRIG);
   assign result.done_res      = done;
   assign result.timed_out     = tmo_in;
   assign result.valid_res     = hit_in;
   assign result.echo_count    = high_in;

endmodule

`default_nettype wire

FILE: sv/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger top level: register port, sequencer and result pipeline.
//
// Each input item is one tick: a start request and the sampled echo pin level.
// Each accepted item gives exactly one result item with the trigger pin level,
// a done pulse, the timeout and valid flags of the last finished measurement,
// the echo count and the distance in hundredths of a centimeter.
// The sequencer state advances on the edge at which an item is accepted, so
// one item is taken per cycle while the result side keeps up.
// Results leave through two registers: the sequencer result, then the output
// register where count times coefficient is scaled into the distance.
// An accepted item is held in the sequencer result register and then in the
// output register, which drives rsp_valid; one item per cycle while rsp_stall
// is low. When rsp_stall is high the output register holds and req_stall rises
// once the first result register is also full, so no item is lost.
// Synchronous reset returns the sequencer to idle, clears both result stages
// and loads the register defaults. Registers sit at byte addresses 0, 4, 8:
// trigger length, timeout and distance coefficient; write them only while idle.
`default_nettype none
`include "assert_macros.svh"

module ultrasonic_echo_ranger (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire                                req_start_req,
   input  wire                                req_echo_level,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic                               rsp_trigger_level,
   output logic                               rsp_done_res,
   output logic                               rsp_timed_out,
   output logic                               rsp_valid_res,
   output logic [uer_pkg::COUNT_W-1:0]        rsp_echo_count,
   output logic [uer_pkg::DIST_W-1:0]         rsp_distance_centi_cm,
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  [uer_pkg::CSR_AW-1:0]         csr_paddr,
   input  wire  [uer_pkg::CSR_DW-1:0]         csr_pwdata,
   output logic [uer_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                               csr_pready
);

   logic [uer_pkg::TRIG_W-1:0]   trig_ff;
   logic [uer_pkg::TIME_W-1:0]   timeout_ff;
   logic [uer_pkg::COEFF_W-1:0]  coeff_ff;
   logic                         csr_wr;
   logic [1:0]                   csr_idx;

   uer_pkg::ctrl_result_type     ctrl_res;
   uer_pkg::ctrl_result_type     s1_ff;
   logic                         s1_valid_ff;
   logic                         req_take;
   logic                         out_en;
   logic                         s1_move;

   logic                         rsp_valid_ff;
   uer_pkg::ctrl_result_type     rsp_ff;
   logic [uer_pkg::DIST_W-1:0]   dist_ff, dist_in;
   logic [uer_pkg::PROD_W-1:0]   product;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ff    <= uer_pkg::TRIG_RESET;
         timeout_ff <= uer_pkg::TIMEOUT_RESET;
         coeff_ff   <= uer_pkg::COEFF_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            uer_pkg::REG_TRIGGER: trig_ff    <= csr_pwdata[uer_pkg::TRIG_W-1:0];
            uer_pkg::REG_TIMEOUT: timeout_ff <= csr_pwdata[uer_pkg::TIME_W-1:0];
            uer_pkg::REG_COEFF:   coeff_ff   <= csr_pwdata[uer_pkg::COEFF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         uer_pkg::REG_TRIGGER: csr_prdata = uer_pkg::CSR_DW'(trig_ff);
         uer_pkg::REG_TIMEOUT: csr_prdata = uer_pkg::CSR_DW'(timeout_ff);
         uer_pkg::REG_COEFF:   csr_prdata = uer_pkg::CSR_DW'(coeff_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // Handshake and pipeline control
   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_en;
   assign req_take  = req_valid && !req_stall;
   assign s1_move   = s1_valid_ff && out_en;

   uer_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .step          (req_take),
      .start_req     (req_start_req),
      .echo_level    (req_echo_level),
      .trigger_ticks (trig_ff),
      .timeout_ticks (timeout_ff),
      .result        (ctrl_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= ctrl_res;
      end
   end

   // Distance is the count times the Q16 coefficient, fraction dropped.
   assign product = {{uer_pkg::COEFF_W{1'b0}}, s1_ff.echo_count}
                  * {{uer_pkg::COUNT_W{1'b0}}, coeff_ff};
   assign dist_in = product[uer_pkg::FRAC_W +: uer_pkg::DIST_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_ff  <= s1_ff;
         dist_ff <= dist_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_trigger_level     = rsp_ff.trigger_level;
   assign rsp_done_res          = rsp_ff.done_res;
   assign rsp_timed_out         = rsp_ff.timed_out;
   assign rsp_valid_res         = rsp_ff.valid_res;
   assign rsp_echo_count        = rsp_ff.echo_count;
   assign rsp_distance_centi_cm = dist_ff;

   `UER_ASSERT(a_done_trig_low, clock, reset,
      (rsp_valid_ff && rsp_ff.done_res) |-> !rsp_ff.trigger_level,
      "done item shows trigger high")
   `UER_ASSERT(a_valid_has_count, clock, reset,
      (rsp_valid_ff && rsp_ff.valid_res) |-> (rsp_ff.echo_count != '0),
      "valid flag with zero count")
   `UER_ASSERT(a_stall_when_full, clock, reset,
      req_stall |-> (s1_valid_ff && rsp_valid_ff),
      "input stalled with free stage")
   `UER_ASSERT_NEXT(a_take_fills, clock, reset, req_take, s1_valid_ff,
      "accepted item missing from stage")

endmodule

`default_nettype wire
